>>> rtl/core/trr_pkg.sv
// Shared types, constants and helpers for the track ring offset core.
// Depends on nothing; compile first.
`default_nettype none

package trr_pkg;

    // Ring geometry
    localparam int TRACK_DEPTH = 32;
    localparam int SLOT_W      = $clog2(TRACK_DEPTH);

    // Field widths
    localparam int LAT_W      = 31;
    localparam int LON_W      = 32;
    localparam int CLIMB_W    = 14;
    localparam int SLOT_OUT_W = 5;
    localparam int OFS_W      = 28;
    localparam int MAG_W      = 27;

    // Chord datapath widths
    localparam int DIFF_W  = 33;
    localparam int WIDE_W  = 33;
    localparam int ANG_W   = 31;
    localparam int X2_W    = 32;
    localparam int DIV_W   = 33;
    localparam int K_W     = 9;
    localparam int TERMS   = 8;
    localparam int TERM_W  = $clog2(TERMS);
    localparam int MUL_W   = 32;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int PRE_W   = 3;
    localparam int POST_W  = 6;

    // Angle and scale constants (angles in 0.5e-7 degree half-angle units)
    localparam logic [WIDE_W:0]   FULL_CIRCLE    = 34'd7200000000;
    localparam logic [WIDE_W-1:0] HALF_CIRCLE    = 33'd3600000000;
    localparam logic [WIDE_W-1:0] QUARTER_CIRCLE = 33'd1800000000;
    localparam logic [MUL_W-1:0]  RAD_FACTOR     = 32'd4024455254;
    localparam logic [MUL_W-1:0]  DIAM_DM        = 32'd127420000;
    localparam logic [ANG_W-1:0]  Q30_ONE        = 31'h4000_0000;

    typedef logic [SLOT_W-1:0] slot_t;

    typedef struct packed {
        logic signed [LAT_W-1:0]   lat;
        logic signed [LON_W-1:0]   lon;
        logic signed [CLIMB_W-1:0] climb;
    } store_entry_t;

    typedef struct packed {
        logic                     start;
        logic signed [DIFF_W-1:0] diff;
    } chord_req_t;

    typedef struct packed {
        logic                    done;
        logic signed [OFS_W-1:0] chord;
    } chord_rsp_t;

    // Exact floor division by a series divisor: ((n >> pre) * magic) >> post
    typedef struct packed {
        logic [PRE_W-1:0]  pre;
        logic [MUL_W-1:0]  magic;
        logic [POST_W-1:0] post;
    } recip_t;

    typedef enum logic [3:0] {
        C_IDLE, C_FOLD, C_MIRROR, C_MX, C_X, C_MX2, C_X2, C_MT,
        C_DLOAD, C_DIV, C_TUPD, C_MS, C_S, C_MM, C_DONE
    } chord_state_t;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_LOAD, S_NWAIT, S_EAST, S_EWAIT, S_PUSH
    } trr_state_t;

    // Divisors of the nested sine series, innermost term first
    function automatic logic [K_W-1:0] series_div(input logic [TERM_W-1:0] idx);
        logic [K_W-1:0] k;
        unique case (idx)
            3'd0:    k = 9'd272;
            3'd1:    k = 9'd210;
            3'd2:    k = 9'd156;
            3'd3:    k = 9'd110;
            3'd4:    k = 9'd72;
            3'd5:    k = 9'd42;
            3'd6:    k = 9'd20;
            default: k = 9'd6;
        endcase
        return k;
    endfunction

    // Reciprocals of the series divisors, exact for dividends below 2^32
    function automatic recip_t series_recip(input logic [TERM_W-1:0] idx);
        recip_t r;
        unique case (idx)
            3'd0:    r = {3'd4, 32'd4042322161, 6'd36};
            3'd1:    r = {3'd1, 32'd2617884829, 6'd38};
            3'd2:    r = {3'd2, 32'd3524075731, 6'd37};
            3'd3:    r = {3'd1, 32'd2498890064, 6'd37};
            3'd4:    r = {3'd3, 32'd3817748708, 6'd35};
            3'd5:    r = {3'd1, 32'd3272356036, 6'd36};
            3'd6:    r = {3'd2, 32'd3435973837, 6'd34};
            default: r = {3'd1, 32'd2863311531, 6'd33};
        endcase
        return r;
    endfunction

    // Advance a ring slot with wrap
    function automatic slot_t slot_inc(input slot_t s);
        return (s == SLOT_W'(TRACK_DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/trr_fix_if.sv
// Handshake channel carrying one position fix.
// Depends on trr_pkg.
`default_nettype none

interface trr_fix_if;
    logic                              valid;
    logic                              ready;
    logic signed [trr_pkg::LAT_W-1:0]   latitude;
    logic signed [trr_pkg::LON_W-1:0]   longitude;
    logic signed [trr_pkg::CLIMB_W-1:0] climb_rate;

    modport source (output valid, latitude, longitude, climb_rate, input ready);
    modport sink   (input valid, latitude, longitude, climb_rate, output ready);
endinterface

`default_nettype wire

>>> rtl/core/trr_res_if.sv
// Handshake channel carrying one offset result.
// Depends on trr_pkg.
`default_nettype none

interface trr_res_if;
    logic                                valid;
    logic                                ready;
    logic [trr_pkg::SLOT_OUT_W-1:0]      slot_index;
    logic signed [trr_pkg::OFS_W-1:0]    east_offset;
    logic signed [trr_pkg::OFS_W-1:0]    north_offset;
    logic signed [trr_pkg::CLIMB_W-1:0]  point_climb;
    logic                                final_point;

    modport source (output valid, slot_index, east_offset, north_offset, point_climb,
                    final_point, input ready);
    modport sink   (input valid, slot_index, east_offset, north_offset, point_climb,
                    final_point, output ready);
endinterface

`default_nettype wire

>>> rtl/core/trr_store.sv
// Track point memory: one write port, one registered read port.
// Depends on trr_pkg.
`default_nettype none

module trr_store (
    input  logic                  clk,
    input  logic                  wr_en,
    input  trr_pkg::slot_t        wr_addr,
    input  trr_pkg::store_entry_t wr_data,
    input  logic                  rd_en,
    input  trr_pkg::slot_t        rd_addr,
    output trr_pkg::store_entry_t rd_data
);
    import trr_pkg::*;

    store_entry_t mem [TRACK_DEPTH];

    // Write the new fix
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, hold data between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/trr_chord.sv
// Iterative chord unit: 2R*sin(d/2) in decimetres with one shared multiplier;
// series divisions use reciprocal multiplication. Depends on trr_pkg.
`default_nettype none

module trr_chord (
    input  logic                clk,
    input  logic                rst_n,
    input  trr_pkg::chord_req_t req,
    output trr_pkg::chord_rsp_t rsp
);
    import trr_pkg::*;

    chord_state_t state_reg, state_next;

    logic [WIDE_W-1:0] wide_reg;
    logic              neg_reg;
    logic [ANG_W-1:0]  m_reg;
    logic [ANG_W-1:0]  x_reg;
    logic [X2_W-1:0]   x2_reg;
    logic [ANG_W-1:0]  t_reg;
    logic [ANG_W-1:0]  s_reg;
    logic [DIV_W-1:0]  div_reg;
    logic [TERM_W-1:0] term_reg;
    logic [PROD_W-1:0] prod_reg;

    logic [WIDE_W:0]   m0_sum;
    logic [PROD_W-1:0] rnd31;
    logic [PROD_W-1:0] rnd29;
    logic [K_W-1:0]    k_cur;
    recip_t            recip;
    logic [PROD_W-1:0] quot;
    logic [X2_W-1:0]   s_full;
    logic [MAG_W-1:0]  mag;
    logic [MUL_W-1:0]  mul_a;
    logic [MUL_W-1:0]  mul_b;

    // Reduce the signed difference to one full circle
    assign m0_sum = (WIDE_W + 1)'(req.diff) + (req.diff[DIFF_W-1] ? FULL_CIRCLE : '0);

    assign rnd31 = prod_reg + 64'h0000_0000_8000_0000;
    assign rnd29 = prod_reg + 64'h0000_0000_2000_0000;
    assign k_cur = series_div(term_reg);
    assign recip = series_recip(term_reg);

    // Quotient out of the reciprocal product
    assign quot = prod_reg >> recip.post;

    assign s_full = rnd29[61:30];
    assign mag    = rnd29[56:30];

    // Select multiplier operands per step
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            C_MX:
            begin
                mul_a = {1'b0, m_reg};
                mul_b = RAD_FACTOR;
            end
            C_MX2:
            begin
                mul_a = {1'b0, x_reg};
                mul_b = {1'b0, x_reg};
            end
            C_MT:
            begin
                mul_a = x2_reg;
                mul_b = {1'b0, t_reg};
            end
            C_DIV:
            begin
                mul_a = MUL_W'(div_reg >> recip.pre);
                mul_b = recip.magic;
            end
            C_MS:
            begin
                mul_a = {1'b0, x_reg};
                mul_b = {1'b0, t_reg};
            end
            C_MM:
            begin
                mul_a = {1'b0, s_reg};
                mul_b = DIAM_DM;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequence the steps
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            C_IDLE:   if (req.start) state_next = C_FOLD;
            C_FOLD:   state_next = C_MIRROR;
            C_MIRROR: state_next = C_MX;
            C_MX:     state_next = C_X;
            C_X:      state_next = C_MX2;
            C_MX2:    state_next = C_X2;
            C_X2:     state_next = C_MT;
            C_MT:     state_next = C_DLOAD;
            C_DLOAD:  state_next = C_DIV;
            C_DIV:    state_next = C_TUPD;
            C_TUPD:   state_next = (term_reg == TERM_W'(TERMS - 1)) ? C_MS : C_MT;
            C_MS:     state_next = C_S;
            C_S:      state_next = C_MM;
            C_MM:     state_next = C_DONE;
            C_DONE:   state_next = C_IDLE;
            default:  state_next = C_IDLE;
        endcase
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            C_IDLE:
            begin
                wide_reg <= m0_sum[WIDE_W-1:0];
            end
            C_FOLD:
            begin
                // upper half of the circle flips the sign
                neg_reg <= wide_reg >= HALF_CIRCLE;
                if (wide_reg >= HALF_CIRCLE)
                begin
                    wide_reg <= wide_reg - HALF_CIRCLE;
                end
            end
            C_MIRROR:
            begin
                m_reg <= (wide_reg > QUARTER_CIRCLE) ? ANG_W'(HALF_CIRCLE - wide_reg)
                                                     : ANG_W'(wide_reg);
            end
            C_X:
            begin
                x_reg <= rnd31[62:32];
            end
            C_X2:
            begin
                x2_reg   <= rnd29[61:30];
                t_reg    <= Q30_ONE;
                term_reg <= '0;
            end
            C_DLOAD:
            begin
                // rounded dividend over 2^30; every divisor is even
                div_reg <= DIV_W'(prod_reg[61:30]) + DIV_W'(k_cur[K_W-1:1]);
            end
            C_TUPD:
            begin
                t_reg    <= (quot >= PROD_W'(Q30_ONE)) ? '0
                                                       : ANG_W'(PROD_W'(Q30_ONE) - quot);
                term_reg <= term_reg + 1'b1;
            end
            C_S:
            begin
                s_reg <= (s_full > X2_W'(Q30_ONE)) ? Q30_ONE : ANG_W'(s_full);
            end
            default:
            begin
            end
        endcase
    end

    // Signed chord out of the last product
    assign rsp.done  = state_reg == C_DONE;
    assign rsp.chord = neg_reg ? -$signed(OFS_W'(mag)) : $signed(OFS_W'(mag));

endmodule

`default_nettype wire

>>> rtl/core/track_ring_relative_offsets_core.sv
// Track ring core: stores each fix in a 32-slot ring (at most 31 points kept,
// oldest dropped when full) and then sends, oldest first, one transfer per
// stored point with its east/north chord offset to the newest point in
// decimetres; the newest point comes last with zero offsets and final_point
// set. The fix is written in the cycle it is taken. Each older point needs two
// evaluations of the iterative chord unit (eight series terms, divisions done
// by reciprocal multiplication); a new fix is taken once the final transfer
// has been loaded into the output register.
// Depends on trr_pkg, trr_fix_if, trr_res_if, trr_store, trr_chord.
`default_nettype none

module track_ring_relative_offsets_core (
    input  logic             clk,
    input  logic             rst_n,
    trr_fix_if.sink          fix,
    trr_res_if.source        offset
);
    import trr_pkg::*;

    trr_state_t state_reg, state_next;

    slot_t write_slot_reg;
    slot_t oldest_slot_reg;
    slot_t newest_slot_reg;
    slot_t cursor_reg;
    logic  final_reg;

    logic signed [LAT_W-1:0]   lat_new_reg;
    logic signed [LON_W-1:0]   lon_new_reg;
    logic signed [CLIMB_W-1:0] climb_new_reg;
    logic signed [OFS_W-1:0]   north_reg;
    logic signed [OFS_W-1:0]   east_reg;

    logic                      out_valid_reg;
    logic [SLOT_OUT_W-1:0]     out_slot_reg;
    logic signed [OFS_W-1:0]   out_east_reg;
    logic signed [OFS_W-1:0]   out_north_reg;
    logic signed [CLIMB_W-1:0] out_climb_reg;
    logic                      out_final_reg;

    logic         fix_xfer;
    logic         push;
    slot_t        next_write;
    store_entry_t wr_entry;
    store_entry_t rd_entry;
    logic         rd_en;
    chord_req_t   chord_req;
    chord_rsp_t   chord_rsp;

    assign fix.ready  = state_reg == S_IDLE;
    assign fix_xfer   = fix.valid && fix.ready;
    assign next_write = slot_inc(write_slot_reg);
    assign push       = (state_reg == S_PUSH) && (!out_valid_reg || offset.ready);
    assign rd_en      = (state_reg == S_READ) && (cursor_reg != newest_slot_reg);

    assign wr_entry.lat   = fix.latitude;
    assign wr_entry.lon   = fix.longitude;
    assign wr_entry.climb = fix.climb_rate;

    trr_store u_store (
        .clk     (clk),
        .wr_en   (fix_xfer),
        .wr_addr (write_slot_reg),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (cursor_reg),
        .rd_data (rd_entry)
    );

    // Latitude difference first, then longitude
    always_comb
    begin
        chord_req.start = (state_reg == S_LOAD) || (state_reg == S_EAST);
        if (state_reg == S_EAST)
        begin
            chord_req.diff = DIFF_W'(lon_new_reg) - DIFF_W'(rd_entry.lon);
        end
        else
        begin
            chord_req.diff = DIFF_W'(lat_new_reg) - DIFF_W'(rd_entry.lat);
        end
    end

    trr_chord u_chord (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (chord_req),
        .rsp   (chord_rsp)
    );

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Walk the ring from oldest to newest
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (fix_xfer) state_next = S_READ;
            S_READ:  state_next = (cursor_reg == newest_slot_reg) ? S_PUSH : S_LOAD;
            S_LOAD:  state_next = S_NWAIT;
            S_NWAIT: if (chord_rsp.done) state_next = S_EAST;
            S_EAST:  state_next = S_EWAIT;
            S_EWAIT: if (chord_rsp.done) state_next = S_PUSH;
            S_PUSH:  if (push) state_next = final_reg ? S_IDLE : S_READ;
            default: state_next = S_IDLE;
        endcase
    end

    // Ring pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_slot_reg  <= '0;
            oldest_slot_reg <= '0;
            newest_slot_reg <= '0;
            cursor_reg      <= '0;
            final_reg       <= 1'b0;
        end
        else
        begin
            if (fix_xfer)
            begin
                write_slot_reg  <= next_write;
                newest_slot_reg <= write_slot_reg;
                // drop the oldest point when the ring is full
                if (next_write == oldest_slot_reg)
                begin
                    oldest_slot_reg <= slot_inc(oldest_slot_reg);
                    cursor_reg      <= slot_inc(oldest_slot_reg);
                end
                else
                begin
                    cursor_reg <= oldest_slot_reg;
                end
            end
            if (state_reg == S_READ)
            begin
                final_reg <= cursor_reg == newest_slot_reg;
            end
            if (push && !final_reg)
            begin
                cursor_reg <= slot_inc(cursor_reg);
            end
        end
    end

    // Newest fix and chord results
    always_ff @(posedge clk)
    begin
        if (fix_xfer)
        begin
            lat_new_reg   <= fix.latitude;
            lon_new_reg   <= fix.longitude;
            climb_new_reg <= fix.climb_rate;
        end
        if (state_reg == S_NWAIT && chord_rsp.done)
        begin
            north_reg <= chord_rsp.chord;
        end
        if (state_reg == S_EWAIT && chord_rsp.done)
        begin
            east_reg <= -chord_rsp.chord;
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (offset.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_slot_reg  <= SLOT_OUT_W'(cursor_reg);
            out_final_reg <= final_reg;
            if (final_reg)
            begin
                out_east_reg  <= '0;
                out_north_reg <= '0;
                out_climb_reg <= climb_new_reg;
            end
            else
            begin
                out_east_reg  <= east_reg;
                out_north_reg <= north_reg;
                out_climb_reg <= rd_entry.climb;
            end
        end
    end

    assign offset.valid        = out_valid_reg;
    assign offset.slot_index   = out_slot_reg;
    assign offset.east_offset  = out_east_reg;
    assign offset.north_offset = out_north_reg;
    assign offset.point_climb  = out_climb_reg;
    assign offset.final_point  = out_final_reg;

endmodule

`default_nettype wire
